/* rtl/pnes_pkg.sv */
// ----------------------------------------------------------------------------
// pnes_pkg
// Shared codes, tables and the job record passed from front to back.
// ----------------------------------------------------------------------------
package pnes_pkg;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_PLAY      = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_DUTY_UP   = 3'd3;
  localparam logic [2:0] CMD_DUTY_DOWN = 3'd4;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ATTACK  = 2'd1;
  localparam logic [1:0] PH_SUSTAIN = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  localparam logic [1:0] REG_DUTY_VOL = 2'd0;
  localparam logic [1:0] REG_TIMER_LO = 2'd1;
  localparam logic [1:0] REG_TIMER_HI = 2'd2;

  localparam logic [3:0] SUSTAIN_START = 4'd12;
  localparam logic [3:0] FRAME_MAX     = 4'd15;
  localparam logic [3:0] VIB_LAST      = 4'd9;
  localparam logic [3:0] VIB_HALF      = 4'd5;
  localparam logic [10:0] VIB_STEP     = 11'd2;
  localparam int unsigned MAX_WRITES   = 3;

  // up to three register writes caused by one command
  typedef struct packed {
    logic [1:0]            nwr;
    logic [2:0][1:0]       sel;
    logic [2:0][7:0]       val;
    logic                  playing;
  } pnes_job_t;

  function automatic logic [3:0] attack_vol(input logic [3:0] fc);
    logic [3:0] v;
    begin
      case (fc)
        4'd0:    v = 4'd4;
        4'd1:    v = 4'd8;
        default: v = 4'd12;
      endcase
      return v;
    end
  endfunction

  function automatic logic [3:0] release_vol(input logic [3:0] fc);
    logic [3:0] v;
    begin
      case (fc)
        4'd0:    v = 4'd9;
        4'd1:    v = 4'd6;
        4'd2:    v = 4'd3;
        default: v = 4'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* rtl/pulse_note_envelope_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// pulse_note_envelope_sequencer_unit
// Per-frame note sequencer for a square-wave sound channel: envelope, duty,
// vibrato timer rewrites, issued as a stream of register writes.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  input    in_valid / in_ready    command, timer_period
//  output   out_valid / out_ready  write_valid, reg_select, reg_value,
//                                  playing, last
//
//  a command is decoded and its writes built in the cycle it is accepted;
//  it enters the job queue and is taken whenever the queue has room.
//  results leave one per cycle unless the output stalls; each command yields
//  1 to 3 results, one per write or one empty; the back end sets the rate.
//  reset clears the note state, empties the queue and the output register.
//  a stalled output fills the output register, then the queue, then drops
//  in_ready.
// ----------------------------------------------------------------------------
module pulse_note_envelope_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [10:0] timer_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_valid,
  output logic [1:0]  reg_select,
  output logic [7:0]  reg_value,
  output logic        playing,
  output logic        last
);
  import pnes_pkg::*;

  pnes_job_t new_job;
  pnes_job_t head_job;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  pnes_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .command      (command),
    .timer_period (timer_period),
    .job          (new_job)
  );

  pnes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (new_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (head_job)
  );

  pnes_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_not_empty),
    .job_in      (head_job),
    .job_pop     (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_valid (write_valid),
    .reg_select  (reg_select),
    .reg_value   (reg_value),
    .playing     (playing),
    .last        (last)
  );

endmodule

/* rtl/pnes_front.sv */
// ----------------------------------------------------------------------------
// pnes_front
// Holds the note state, decodes each command and builds its list of writes.
// ----------------------------------------------------------------------------
module pnes_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [2:0]         command,
  input  logic [10:0]        timer_period,
  output pnes_pkg::pnes_job_t job
);
  import pnes_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [3:0]  frame_count, frame_count_next;
  logic [3:0]  vibrato_phase, vibrato_phase_next;
  logic [1:0]  duty, duty_next;
  logic [10:0] note_timer, note_timer_next;
  logic [2:0]  shadow, shadow_next;
  logic        do_frame;
  logic [10:0] vib_timer;
  logic [3:0]  vol;

  always_comb begin
    phase_next         = phase;
    frame_count_next   = frame_count;
    vibrato_phase_next = vibrato_phase;
    duty_next          = duty;
    note_timer_next    = note_timer;
    shadow_next        = shadow;
    do_frame           = 1'b0;
    unique case (command)
      CMD_TICK: begin
        unique case (phase)
          PH_ATTACK: begin
            do_frame = 1'b1;
            if (frame_count >= 4'd2) begin
              phase_next         = PH_SUSTAIN;
              frame_count_next   = 4'd0;
              vibrato_phase_next = 4'd0;
            end else begin
              frame_count_next = frame_count + 4'd1;
            end
          end
          PH_SUSTAIN: begin
            do_frame = 1'b1;
            if (frame_count != FRAME_MAX) begin
              frame_count_next = frame_count + 4'd1;
            end
            vibrato_phase_next = (vibrato_phase >= VIB_LAST) ? 4'd0 : vibrato_phase + 4'd1;
          end
          PH_RELEASE: begin
            if (frame_count >= 4'd3) begin
              phase_next       = PH_IDLE;
              frame_count_next = 4'd0;
            end else begin
              frame_count_next = frame_count + 4'd1;
              do_frame         = 1'b1;
            end
          end
          default: ;
        endcase
      end
      CMD_PLAY: begin
        note_timer_next  = timer_period;
        phase_next       = PH_ATTACK;
        frame_count_next = 4'd0;
        do_frame         = 1'b1;
      end
      CMD_STOP: begin
        phase_next       = PH_RELEASE;
        frame_count_next = 4'd0;
        do_frame         = 1'b1;
      end
      CMD_DUTY_UP: begin
        if (duty != 2'd3) duty_next = duty + 2'd1;
      end
      CMD_DUTY_DOWN: begin
        if (duty != 2'd0) duty_next = duty - 2'd1;
      end
      default: ;
    endcase

    // writes are built from the state after the update
    job         = '0;
    job.playing = (phase_next != PH_IDLE);
    vib_timer   = (vibrato_phase_next == 4'd0) ? note_timer_next + VIB_STEP : note_timer_next;
    vol         = (phase_next == PH_ATTACK) ? attack_vol(frame_count_next)
                                            : release_vol(frame_count_next);
    if (do_frame) begin
      unique case (phase_next) inside
        PH_ATTACK, PH_RELEASE: begin
          job.sel[0] = REG_DUTY_VOL;
          job.val[0] = {duty, 2'b11, vol};
          job.sel[1] = REG_TIMER_LO;
          job.val[1] = note_timer_next[7:0];
          job.sel[2] = REG_TIMER_HI;
          job.val[2] = {5'd0, note_timer_next[10:8]};
          if (frame_count_next == 4'd0) begin
            job.nwr     = 2'd3;
            shadow_next = note_timer_next[10:8];
          end else begin
            job.nwr = 2'd1;
          end
        end
        PH_SUSTAIN: begin
          if (frame_count_next >= SUSTAIN_START &&
              (vibrato_phase_next == 4'd0 || vibrato_phase_next == VIB_HALF)) begin
            job.sel[0] = REG_TIMER_LO;
            job.val[0] = vib_timer[7:0];
            job.sel[1] = REG_TIMER_HI;
            job.val[1] = {5'd0, vib_timer[10:8]};
            if (vib_timer[10:8] != shadow) begin
              job.nwr     = 2'd2;
              shadow_next = vib_timer[10:8];
            end else begin
              job.nwr = 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_count   <= 4'd0;
      vibrato_phase <= 4'd0;
      duty          <= 2'd0;
      note_timer    <= 11'd0;
      shadow        <= 3'd0;
    end else if (take) begin
      phase         <= phase_next;
      frame_count   <= frame_count_next;
      vibrato_phase <= vibrato_phase_next;
      duty          <= duty_next;
      note_timer    <= note_timer_next;
      shadow        <= shadow_next;
    end
  end

endmodule

/* rtl/pnes_queue.sv */
// ----------------------------------------------------------------------------
// pnes_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module pnes_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pnes_pkg::pnes_job_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output pnes_pkg::pnes_job_t pop_data
);
  import pnes_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pnes_job_t        store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/pnes_back.sv */
// ----------------------------------------------------------------------------
// pnes_back
// Takes jobs from the queue and sends their writes one per cycle through an
// output register, while the output is not stalled.
// ----------------------------------------------------------------------------
module pnes_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  pnes_pkg::pnes_job_t job_in,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                write_valid,
  output logic [1:0]          reg_select,
  output logic [7:0]          reg_value,
  output logic                playing,
  output logic                last
);
  import pnes_pkg::*;

  pnes_job_t  job;
  logic       busy;
  logic [1:0] idx;
  logic       out_free;
  logic       emit;
  logic       cur_last;

  assign out_free = !out_valid || out_ready;
  assign emit     = busy && out_free;
  assign cur_last = (job.nwr == 2'd0) || (idx == job.nwr - 2'd1);
  assign job_pop  = job_valid && (!busy || (emit && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (emit && cur_last) begin
        busy <= 1'b0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
    if (emit) begin
      // a job with no writes still yields one empty transaction
      write_valid <= (job.nwr != 2'd0);
      reg_select  <= (job.nwr != 2'd0) ? job.sel[idx] : REG_DUTY_VOL;
      reg_value   <= (job.nwr != 2'd0) ? job.val[idx] : 8'd0;
      playing     <= job.playing;
      last        <= cur_last;
    end
  end

endmodule

/* verif/pnes_write_checker.sv */
// ----------------------------------------------------------------------------
// pnes_write_checker
// Watches both channels of the note sequencer, predicts the register writes
// each accepted command causes and compares every result field by field.
// ----------------------------------------------------------------------------
module pnes_write_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  command,
  input  logic [10:0] timer_period,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        write_valid,
  input  logic [1:0]  reg_select,
  input  logic [7:0]  reg_value,
  input  logic        playing,
  input  logic        last,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pnes_pkg::*;

  localparam logic [3:0] ATTACK_FRAMES  = 4'd3;
  localparam logic [3:0] RELEASE_FRAMES = 4'd4;
  localparam logic [1:0] DUTY_MAX       = 2'd3;
  localparam int         PRINT_CAP      = 40;
  // volume per frame, index 0 first
  localparam logic [2:0][3:0] ATTACK_LEVELS  = {4'd12, 4'd8, 4'd4};
  localparam logic [3:0][3:0] RELEASE_LEVELS = {4'd0, 4'd3, 4'd6, 4'd9};

  typedef struct packed {
    logic       wr;
    logic [1:0] sel;
    logic [7:0] val;
    logic       playing_bit;
    logic       is_last;
  } reg_write_t;

  reg_write_t writes_due[$];
  int         err_count = 0;

  // predicted channel state
  logic [1:0]  note_phase;
  logic [3:0]  frame_cnt;
  logic [3:0]  vib_cnt;
  logic [1:0]  duty_lvl;
  logic [10:0] note_period;
  logic [7:0]  hi_shadow;

  // writes built for the command being predicted
  int         n_writes;
  logic [1:0] w_sel [3];
  logic [7:0] w_val [3];

  assign mismatches = err_count;

  task flag_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  task queue_write(input logic [1:0] sel, input logic [7:0] val);
    if (n_writes < MAX_WRITES) begin
      w_sel[n_writes] = sel;
      w_val[n_writes] = val;
      n_writes++;
    end
  endtask

  task write_duty_vol(input logic [3:0] vol);
    queue_write(REG_DUTY_VOL, {duty_lvl, 2'b11, vol});
  endtask

  task write_period(input logic [10:0] t);
    queue_write(REG_TIMER_LO, t[7:0]);
    queue_write(REG_TIMER_HI, {5'd0, t[10:8]});
    hi_shadow = {5'd0, t[10:8]};
  endtask

  task frame_writes();
    logic [10:0] t;
    logic [7:0]  hi;
    case (note_phase)
      PH_ATTACK: begin
        write_duty_vol(ATTACK_LEVELS[(frame_cnt < ATTACK_FRAMES) ? frame_cnt[1:0] : 2'd2]);
        if (frame_cnt == 4'd0)
          write_period(note_period);
      end
      PH_SUSTAIN: begin
        if (frame_cnt >= SUSTAIN_START && (vib_cnt == 4'd0 || vib_cnt == VIB_HALF)) begin
          t = note_period;
          // vibrato peak, wraps at 11 bits
          if (vib_cnt == 4'd0)
            t = note_period + VIB_STEP;
          queue_write(REG_TIMER_LO, t[7:0]);
          hi = {5'd0, t[10:8]};
          if (hi != hi_shadow) begin
            queue_write(REG_TIMER_HI, hi);
            hi_shadow = hi;
          end
        end
      end
      PH_RELEASE: begin
        write_duty_vol(RELEASE_LEVELS[(frame_cnt < RELEASE_FRAMES) ? frame_cnt[1:0] : 2'd3]);
        if (frame_cnt == 4'd0)
          write_period(note_period);
      end
      default: ;
    endcase
  endtask

  task predict_command(input logic [2:0] cmd, input logic [10:0] tp);
    reg_write_t w;
    logic       now_playing;
    n_writes = 0;
    case (cmd)
      CMD_TICK: begin
        case (note_phase)
          PH_ATTACK: begin
            frame_cnt = frame_cnt + 4'd1;
            if (frame_cnt >= ATTACK_FRAMES) begin
              note_phase = PH_SUSTAIN;
              frame_cnt  = 4'd0;
              vib_cnt    = 4'd0;
            end
            frame_writes();
          end
          PH_SUSTAIN: begin
            if (frame_cnt < FRAME_MAX)
              frame_cnt = frame_cnt + 4'd1;
            vib_cnt = (vib_cnt >= VIB_LAST) ? 4'd0 : vib_cnt + 4'd1;
            frame_writes();
          end
          PH_RELEASE: begin
            frame_cnt = frame_cnt + 4'd1;
            if (frame_cnt >= RELEASE_FRAMES) begin
              note_phase = PH_IDLE;
              frame_cnt  = 4'd0;
            end else begin
              frame_writes();
            end
          end
          default: ;
        endcase
      end
      CMD_PLAY: begin
        note_period = tp;
        note_phase  = PH_ATTACK;
        frame_cnt   = 4'd0;
        frame_writes();
      end
      CMD_STOP: begin
        note_phase = PH_RELEASE;
        frame_cnt  = 4'd0;
        frame_writes();
      end
      CMD_DUTY_UP: begin
        if (duty_lvl < DUTY_MAX)
          duty_lvl = duty_lvl + 2'd1;
      end
      CMD_DUTY_DOWN: begin
        if (duty_lvl > 2'd0)
          duty_lvl = duty_lvl - 2'd1;
      end
      default: ;
    endcase

    now_playing = (note_phase != PH_IDLE);
    if (n_writes == 0) begin
      w.wr          = 1'b0;
      w.sel         = REG_DUTY_VOL;
      w.val         = 8'd0;
      w.playing_bit = now_playing;
      w.is_last     = 1'b1;
      writes_due.push_back(w);
    end else begin
      for (int k = 0; k < n_writes; k++) begin
        w.wr          = 1'b1;
        w.sel         = w_sel[k];
        w.val         = w_val[k];
        w.playing_bit = now_playing;
        w.is_last     = (k == n_writes - 1);
        writes_due.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    reg_write_t got;
    reg_write_t want;
    if (rst) begin
      note_phase  = PH_IDLE;
      frame_cnt   = 4'd0;
      vib_cnt     = 4'd0;
      duty_lvl    = 2'd0;
      note_period = 11'd0;
      hi_shadow   = 8'd0;
      writes_due.delete();
    end else begin
      // input first, so a same-cycle result would still find its expectation
      if (in_valid && in_ready)
        predict_command(command, timer_period);
      if (out_valid && out_ready) begin
        got.wr          = write_valid;
        got.sel         = reg_select;
        got.val         = reg_value;
        got.playing_bit = playing;
        got.is_last     = last;
        if (writes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result sel %0d val 0x%02h", reg_select,
                                  reg_value));
        end else begin
          want = writes_due.pop_front();
          if (got.wr !== want.wr)
            flag_mismatch($sformatf("write_valid %b, expected %b", got.wr, want.wr));
          if (got.sel !== want.sel)
            flag_mismatch($sformatf("reg_select %0d, expected %0d", got.sel, want.sel));
          if (got.val !== want.val)
            flag_mismatch($sformatf("reg_value 0x%02h, expected 0x%02h", got.val, want.val));
          if (got.playing_bit !== want.playing_bit)
            flag_mismatch($sformatf("playing %b, expected %b", got.playing_bit,
                                    want.playing_bit));
          if (got.is_last !== want.is_last)
            flag_mismatch($sformatf("last %b, expected %b", got.is_last, want.is_last));
        end
      end
    end
    outstanding <= writes_due.size();
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the pulse note sequencer with random gaps and output
// stalls, checks every register write through the checker, gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pnes_pkg::*;

  localparam logic [2:0] CMD_RESERVED    = 3'd7;
  localparam int         ITEMS_PER_PHASE = 50;
  localparam int         HOLD_CYCLES     = 300;
  localparam int         DRAIN_LIMIT     = 20000;
  localparam int         SETTLE_CYCLES   = 20;
  localparam int         LIMIT_NS        = 2_000_000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic [2:0]  command      = CMD_TICK;
  logic [10:0] timer_period = 11'd0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        write_valid;
  logic [1:0]  reg_select;
  logic [7:0]  reg_value;
  logic        playing;
  logic        last;

  int mismatches;
  int outstanding;
  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  int items_sent = 0;

  pulse_note_envelope_sequencer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .timer_period (timer_period),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_valid  (write_valid),
    .reg_select   (reg_select),
    .reg_value    (reg_value),
    .playing      (playing),
    .last         (last)
  );

  pnes_write_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .timer_period (timer_period),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_valid  (write_valid),
    .reg_select   (reg_select),
    .reg_value    (reg_value),
    .playing      (playing),
    .last         (last),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #LIMIT_NS;
    $display("timeout with %0d results still expected", outstanding);
    $display("Verification failed");
    $finish;
  end

  // called right after a rising edge; returns at the edge that takes the transaction
  task send_command(input logic [2:0] cmd, input logic [10:0] tp);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    timer_period <= tp;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
  endtask

  task drain(input int limit);
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic logic [10:0] pick_period();
    logic [10:0] p;
    p = 11'($urandom_range(0, 2047));
    // half the notes sit just below a high-byte carry so vibrato crosses it
    if ($urandom_range(0, 1) == 1)
      p[7:0] = 8'hFC + 8'($urandom_range(0, 3));
    return p;
  endfunction

  task play_phrase();
    int frames;
    send_command(CMD_PLAY, pick_period());
    frames = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 20);
    repeat (frames) begin
      if ($urandom_range(0, 7) == 0)
        send_command(($urandom_range(0, 1) == 1) ? CMD_DUTY_UP : CMD_DUTY_DOWN, 11'($urandom));
      else
        send_command(CMD_TICK, 11'($urandom));
    end
    if ($urandom_range(0, 5) != 0) begin
      send_command(CMD_STOP, 11'($urandom));
      repeat ($urandom_range(0, 6))
        send_command(CMD_TICK, 11'($urandom));
    end
  endtask

  task run_phase(input int gap, input int stall, input bit squeeze);
    int stop_at;
    // sender waits for every outstanding write before the phase starts
    drain(DRAIN_LIMIT);
    gap_pct = gap;
    stall_pct <= stall;
    if (squeeze) begin
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
    stop_at = items_sent + ITEMS_PER_PHASE;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8)
        play_phrase();
      else
        send_command(3'($urandom_range(0, 7)), 11'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle commands, saturation, stop while idle, restart while busy
    send_command(CMD_TICK, 11'd0);
    send_command(CMD_DUTY_DOWN, 11'h7FF);
    send_command(CMD_RESERVED, 11'h7FF);
    send_command(CMD_STOP, 11'd0);
    repeat (4) send_command(CMD_TICK, 11'd0);
    send_command(CMD_PLAY, 11'h7FF);
    repeat (4) send_command(CMD_DUTY_UP, 11'd0);
    repeat (3) send_command(CMD_TICK, 11'h7FF);
    send_command(CMD_PLAY, 11'd0);
    send_command(CMD_TICK, 11'd0);
    send_command(CMD_STOP, 11'h7FF);
    send_command(CMD_DUTY_DOWN, 11'd0);
    repeat (4) send_command(CMD_TICK, 11'd0);

    run_phase(0, 0, 1'b1);
    run_phase(85, 0, 1'b0);
    run_phase(0, 85, 1'b0);
    run_phase(33, 33, 1'b0);

    drain(DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outstanding != 0)
      $display("%0d expected results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/pnes_pkg.sv
rtl/pnes_front.sv
rtl/pnes_queue.sv
rtl/pnes_back.sv
rtl/pulse_note_envelope_sequencer_unit.sv
verif/pnes_write_checker.sv
verif/tb_top.sv
